[sv/hsdsm_pkg.sv]
// Shared types and constants for the deep-shadow hillshade block.
`default_nettype none

package hsdsm_pkg;

  typedef struct packed {
    logic signed [15:0] elevation;
    logic               start_of_frame;
  } hsdsm_in_t;

  typedef struct packed {
    logic [14:0] relief_percent;
    logic        dark_flag;
    logic        last_in_line;
  } hsdsm_out_t;

  typedef enum logic [2:0] {
    CFG_LINE_WIDTH   = 3'd0,
    CFG_INV_EW_RES   = 3'd1,
    CFG_INV_NS_RES   = 3'd2,
    CFG_SIN_ELEV     = 3'd3,
    CFG_COS_ELEV     = 3'd4,
    CFG_SIN_AZIMUTH  = 3'd5,
    CFG_COS_AZIMUTH  = 3'd6,
    CFG_SHADOW_THR   = 3'd7
  } hsdsm_cfg_idx_e;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_RD   = 10'b0000000010,
    S_MA   = 10'b0000000100,
    S_MB   = 10'b0000001000,
    S_MC   = 10'b0000010000,
    S_MD   = 10'b0000100000,
    S_SQ   = 10'b0001000000,
    S_DI   = 10'b0010000000,
    S_DV   = 10'b0100000000,
    S_FIN  = 10'b1000000000
  } hsdsm_state_e;

  localparam int          CfgDataW      = 24;
  localparam logic [12:0] LineWidthRst  = 13'd4096;
  localparam logic [23:0] InvResRst     = 24'd559241;
  localparam logic [15:0] SinElevRst    = 16'd23170;
  localparam logic [15:0] CosElevRst    = 16'd23170;
  localparam logic [15:0] SinAzRst      = 16'd0;
  localparam logic [15:0] CosAzRst      = 16'd32767;
  localparam logic [15:0] ThrRst        = 16'd0;
  localparam logic [5:0]  SqrtLastStep  = 6'd31;
  localparam logic [5:0]  DivLastStep   = 6'd63;
  localparam logic [14:0] ReliefMax     = 15'd25600;

endpackage

`default_nettype wire

[sv/hillshade_deep_shadow_mask.sv]
// Horn 3x3 hillshade of a raster elevation stream: relief and a deep-shadow flag.
//
// Input channel in_valid_i / in_stall_o carries one elevation sample per request
// in raster order; start_of_frame restarts the row and column counts. The output
// channel out_valid_o / out_stall_i carries one result per interior centre pixel,
// emitted with the sample at its lower right. Edge rows and columns give nothing.
// Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_wdata_i); the user
// must write it only while the block is idle, which the block does not enforce.
// Both line stores share one RAM word (older line high, newer line low), read in
// the accept cycle and written back in the next cycle.
// A sample that yields no result passes only the accept and line-store read
// states. One that yields a result passes accept, line-store read, 4 arithmetic
// stages (MA to MD), 32 square-root steps (one result bit a step), 1 divide setup
// and 64 long-division steps, then the load into the output register.
// The output register lets the next sample enter while a result waits; if the
// receiver stalls, a following result holds in its final stage until taken.
// Reset clears counts and window, sets default configuration; not the line stores.
`default_nettype none

module hillshade_deep_shadow_mask
  import hsdsm_pkg::*;
#(
  parameter int MAX_LINE_WIDTH = 4096,
  parameter int ELEV_BITS      = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output      logic            in_stall_o,
  input  wire hsdsm_in_t       in_data_i,
  output      logic            out_valid_o,
  input  wire logic            out_stall_i,
  output      hsdsm_out_t      out_data_o,
  input  wire logic            cfg_we_i,
  input  wire logic [2:0]      cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int AW = $clog2(MAX_LINE_WIDTH);
  localparam int LW = (AW + 1 > 13) ? AW + 1 : 13;

  // configuration
  logic [12:0]        lw_q;
  logic [23:0]        iew_q, ins_q;
  logic signed [15:0] se_q, ce_q, sa_q, ca_q, thr_q;

  // control
  hsdsm_state_e       state_q, state_d;
  logic [AW-1:0]      col_q, col_d;
  logic [1:0]         rows_q, rows_d;
  logic [5:0]         cnt_q;
  logic               out_valid_q;
  logic signed [15:0] win_q [6];

  // datapath
  logic [AW-1:0]      addr_q;
  logic               has_res_q, last_q;
  logic signed [15:0] bot_q;
  logic signed [18:0] numx_q, numy_q;
  logic signed [43:0] px_q, py_q;
  logic signed [31:0] kc_q, ks_q;
  logic [30:0]        amag_q, bmag_q;
  logic               aneg_q, bneg_q;
  logic [61:0]        aa_q, bb_q;
  logic signed [63:0] kb_q, ka_q, num_q;
  logic [63:0]        sqv_q, res_q, bit_q;
  logic [37:0]        den_q;
  logic [63:0]        nsh_q;
  logic [38:0]        rem_q;
  logic [31:0]        quo_q;
  hsdsm_out_t         out_q;

  // accept-time counts
  logic               accept;
  logic [AW-1:0]      cnt_cur;
  logic [1:0]         rows_cur;
  logic [LW-1:0]      lw_ext, w_eff, wm1, cnt_ext;
  logic signed [15:0] bot_in;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign cnt_cur  = in_data_i.start_of_frame ? '0 : col_q;
  assign rows_cur = in_data_i.start_of_frame ? 2'd0 : rows_q;
  assign lw_ext   = LW'(lw_q);
  assign bot_in   = 16'($signed(in_data_i.elevation[ELEV_BITS-1:0]));
  assign cnt_ext  = LW'(cnt_cur);

  always_comb begin
    priority if (lw_ext < LW'(3)) begin
      w_eff = LW'(3);
    end else if (lw_ext > LW'(MAX_LINE_WIDTH)) begin
      w_eff = LW'(MAX_LINE_WIDTH);
    end else begin
      w_eff = lw_ext;
    end
  end
  assign wm1 = w_eff - LW'(1);

  always_comb begin
    col_d  = col_q;
    rows_d = rows_q;
    if (accept) begin
      if (cnt_ext >= wm1) begin
        col_d  = '0;
        rows_d = (rows_cur < 2'd2) ? rows_cur + 2'd1 : rows_cur;
      end else begin
        col_d  = cnt_cur + AW'(1);
        rows_d = rows_cur;
      end
    end
  end

  // line stores
  logic [31:0]        ram_rd;
  logic signed [15:0] top, mid;

  assign top = $signed(ram_rd[31:16]);
  assign mid = $signed(ram_rd[15:0]);

  hsdsm_ram #(
    .WIDTH (32),
    .DEPTH (MAX_LINE_WIDTH)
  ) u_lines (
    .clk_i   (clk_i),
    .we_i    (state_q == S_RD),
    .waddr_i (addr_q),
    .wdata_i ({mid, bot_q}),
    .raddr_i (cnt_cur),
    .rdata_o (ram_rd)
  );

  // Horn gradient numerators
  logic signed [18:0] e0, e1, e2, e3, e5, e6, e7, e8;
  assign e0 = 19'(win_q[0]);
  assign e1 = 19'(win_q[3]);
  assign e2 = 19'(top);
  assign e3 = 19'(win_q[1]);
  assign e5 = 19'(mid);
  assign e6 = 19'(win_q[2]);
  assign e7 = 19'(win_q[5]);
  assign e8 = 19'(bot_q);

  // rounding of scaled gradients
  logic [43:0] pxm, pym, pxr, pyr;
  assign pxm = px_q[43] ? 44'(-px_q) : 44'(px_q);
  assign pym = py_q[43] ? 44'(-py_q) : 44'(py_q);
  assign pxr = pxm + 44'd1024;
  assign pyr = pym + 44'd1024;

  logic signed [31:0] a_s, b_s;
  assign a_s = aneg_q ? -$signed({1'b0, amag_q}) : $signed({1'b0, amag_q});
  assign b_s = bneg_q ? -$signed({1'b0, bmag_q}) : $signed({1'b0, bmag_q});

  // square root step
  logic [63:0] trial;
  assign trial = res_q + bit_q;

  // division step
  logic [38:0] rem_sh;
  assign rem_sh = {rem_q[37:0], nsh_q[63]};

  // final scaling
  logic        neg;
  logic [32:0] sm_sum;
  logic signed [24:0] shade;
  logic [39:0] rl;
  logic [14:0] relief;
  assign neg    = num_q[63];
  assign sm_sum = {1'b0, quo_q} + 33'd512;
  assign shade  = neg ? -$signed({2'b0, sm_sum[32:10]}) : $signed({2'b0, sm_sum[32:10]});
  assign rl     = (({8'b0, quo_q} * 40'd100) + 40'd32768) >> 16;

  always_comb begin
    priority if (neg || quo_q == '0) begin
      relief = '0;
    end else if (rl > 40'(ReliefMax)) begin
      relief = ReliefMax;
    end else begin
      relief = rl[14:0];
    end
  end

  logic fin_load;
  assign fin_load = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_RD;
      S_RD:   state_d = has_res_q ? S_MA : S_IDLE;
      S_MA:   state_d = S_MB;
      S_MB:   state_d = S_MC;
      S_MC:   state_d = S_MD;
      S_MD:   state_d = S_SQ;
      S_SQ:   if (cnt_q == SqrtLastStep) state_d = S_DI;
      S_DI:   state_d = S_DV;
      S_DV:   if (cnt_q == DivLastStep) state_d = S_FIN;
      S_FIN:  if (fin_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      col_q       <= '0;
      rows_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 6; i++) win_q[i] <= '0;
      lw_q  <= LineWidthRst;
      iew_q <= InvResRst;
      ins_q <= InvResRst;
      se_q  <= SinElevRst;
      ce_q  <= CosElevRst;
      sa_q  <= SinAzRst;
      ca_q  <= CosAzRst;
      thr_q <= ThrRst;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      rows_q  <= rows_d;
      if (state_q == S_MD || state_q == S_DI) begin
        cnt_q <= '0;
      end else if (state_q == S_SQ || state_q == S_DV) begin
        cnt_q <= cnt_q + 6'd1;
      end
      if (fin_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == S_RD) begin
        win_q[0] <= win_q[3];
        win_q[1] <= win_q[4];
        win_q[2] <= win_q[5];
        win_q[3] <= top;
        win_q[4] <= mid;
        win_q[5] <= bot_q;
      end
      if (cfg_we_i) begin
        unique case (hsdsm_cfg_idx_e'(cfg_idx_i))
          CFG_LINE_WIDTH:  lw_q  <= cfg_wdata_i[12:0];
          CFG_INV_EW_RES:  iew_q <= cfg_wdata_i;
          CFG_INV_NS_RES:  ins_q <= cfg_wdata_i;
          CFG_SIN_ELEV:    se_q  <= $signed(cfg_wdata_i[15:0]);
          CFG_COS_ELEV:    ce_q  <= $signed(cfg_wdata_i[15:0]);
          CFG_SIN_AZIMUTH: sa_q  <= $signed(cfg_wdata_i[15:0]);
          CFG_COS_AZIMUTH: ca_q  <= $signed(cfg_wdata_i[15:0]);
          CFG_SHADOW_THR:  thr_q <= $signed(cfg_wdata_i[15:0]);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        addr_q    <= cnt_cur;
        bot_q     <= bot_in;
        has_res_q <= (rows_cur >= 2'd2) && (cnt_cur >= AW'(2));
        last_q    <= cnt_ext >= wm1;
      end
      S_RD: begin
        numx_q <= (e0 + (e3 <<< 1) + e6) - (e2 + (e5 <<< 1) + e8);
        numy_q <= (e0 + (e1 <<< 1) + e2) - (e6 + (e7 <<< 1) + e8);
      end
      S_MA: begin
        px_q <= numx_q * $signed({1'b0, iew_q});
        py_q <= numy_q * $signed({1'b0, ins_q});
        kc_q <= ce_q * ca_q;
        ks_q <= ce_q * sa_q;
      end
      S_MB: begin
        amag_q <= pxr[41:11];
        bmag_q <= pyr[41:11];
        aneg_q <= px_q[43];
        bneg_q <= py_q[43];
      end
      S_MC: begin
        aa_q <= amag_q * amag_q;
        bb_q <= bmag_q * bmag_q;
        kb_q <= b_s * kc_q;
        ka_q <= a_s * ks_q;
      end
      S_MD: begin
        // numerator = sin_e*2^31 - cos_e*(b*cos_az - a*sin_az)
        num_q <= ($signed(64'(se_q)) <<< 31) - kb_q + ka_q;
        sqv_q <= 64'h1_0000_0000 + 64'(aa_q) + 64'(bb_q);
        res_q <= '0;
        bit_q <= 64'h4000_0000_0000_0000;
      end
      S_SQ: begin
        if (sqv_q >= trial) begin
          sqv_q <= sqv_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      S_DI: begin
        den_q <= {res_q[31:0], 6'b0};
        nsh_q <= (neg ? 64'(-num_q) : 64'(num_q)) + 64'({res_q[31:0], 5'b0});
        rem_q <= '0;
        quo_q <= '0;
      end
      S_DV: begin
        if (rem_sh >= {1'b0, den_q}) begin
          rem_q <= rem_sh - {1'b0, den_q};
          quo_q <= {quo_q[30:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          quo_q <= {quo_q[30:0], 1'b0};
        end
        nsh_q <= nsh_q << 1;
      end
      S_FIN: begin
        if (fin_load) begin
          out_q.relief_percent <= relief;
          out_q.dark_flag      <= shade <= 25'(thr_q);
          out_q.last_in_line   <= last_q;
        end
      end
      default: ;
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[sv/hsdsm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module hsdsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

[sv/hsdsm_checker.sv]
// Port-level checks for the deep-shadow hillshade block, bound to its top level.
`default_nettype none

module hsdsm_checker
  import hsdsm_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire hsdsm_out_t out_data_o
);

  // hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result changed");

  // one request at a time: busy right after a request is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while previous still in work");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.relief_percent <= ReliefMax)
    else $error("relief beyond saturation");

endmodule

bind hillshade_deep_shadow_mask hsdsm_checker u_hsdsm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the Horn hillshade deep-shadow mask block.
`timescale 1ns / 1ps

module tb_top;
  import hsdsm_pkg::*;

  localparam int RowDepth   = 4096;
  localparam int CycleLimit = 1500000;
  localparam int DrainWait  = 150;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  hsdsm_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  hsdsm_out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = CFG_LINE_WIDTH;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  hillshade_deep_shadow_mask u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  always #1 clk_i = ~clk_i;

  // Mirror of the block's state and registers
  logic [15:0] older_row [RowDepth];
  logic [15:0] newer_row [RowDepth];
  logic [15:0] win_col [6];
  int unsigned col_cnt, rows_cnt;
  logic [12:0] m_width;
  logic [23:0] m_inv_ew, m_inv_ns;
  logic [15:0] m_sin_e, m_cos_e, m_sin_az, m_cos_az, m_thr;

  hsdsm_out_t pending_shade[$];
  int mismatches = 0;
  int cycles = 0;
  int send_idle = 0;
  int recv_idle = 0;
  logic hold_on = 1'b0;
  event hold_ev;
  logic signed [15:0] last_elev = '0;

  function automatic longint round_div(longint n, longint d);
    longint mag, q;
    mag = n < 0 ? -n : n;
    q = (mag + d / 2) / d;
    return n < 0 ? -q : q;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  task automatic shade_pixel(hsdsm_in_t it);
    int unsigned w, c;
    longint top, mid, bot, e0, e1, e2, e3, e5, e6, e7, e8;
    longint numx, numy, a, b, t, num, d, q24, s14, relief;
    longint unsigned ssum;
    hsdsm_out_t r;
    w = m_width;
    if (w < 3) w = 3;
    if (w > RowDepth) w = RowDepth;
    if (it.start_of_frame) begin
      col_cnt = 0;
      rows_cnt = 0;
    end
    c = col_cnt;
    if (c >= RowDepth) c = RowDepth - 1;
    bot = longint'(it.elevation);
    top = longint'($signed(older_row[c]));
    mid = longint'($signed(newer_row[c]));
    older_row[c] = newer_row[c];
    newer_row[c] = it.elevation;
    e0 = $signed(win_col[0]); e1 = $signed(win_col[3]); e2 = top;
    e3 = $signed(win_col[1]); e5 = mid;
    e6 = $signed(win_col[2]); e7 = $signed(win_col[5]); e8 = bot;
    if (rows_cnt >= 2 && c >= 2) begin
      numx = (e0 + 2 * e3 + e6) - (e2 + 2 * e5 + e8);
      numy = (e0 + 2 * e1 + e2) - (e6 + 2 * e7 + e8);
      a = round_div(numx * longint'(m_inv_ew), 2048);
      b = round_div(numy * longint'(m_inv_ns), 2048);
      t = b * longint'($signed(m_cos_az)) - a * longint'($signed(m_sin_az));
      num = longint'($signed(m_sin_e)) * (64'sd1 <<< 31) - longint'($signed(m_cos_e)) * t;
      ssum = (64'd1 << 32) + longint'(a * a) + longint'(b * b);
      d = longint'(int_sqrt(ssum));
      q24 = round_div(num, d * 64);
      s14 = round_div(q24, 1024);
      relief = 0;
      if (q24 > 0) begin
        relief = round_div(q24 * 100, 65536);
        if (relief > 25600) relief = 25600;
      end
      r.relief_percent = relief[14:0];
      r.dark_flag = s14 <= longint'($signed(m_thr));
      r.last_in_line = c >= w - 1;
      pending_shade.push_back(r);
    end
    win_col[0] = win_col[3];
    win_col[1] = win_col[4];
    win_col[2] = win_col[5];
    win_col[3] = top[15:0];
    win_col[4] = mid[15:0];
    win_col[5] = bot[15:0];
    if (col_cnt >= w - 1) begin
      col_cnt = 0;
      if (rows_cnt < 2) rows_cnt++;
    end else begin
      col_cnt++;
    end
  endtask

  // Send one sample; valid stays up if the next request follows at once
  task automatic send_sample(logic signed [15:0] elev, logic sof);
    hsdsm_in_t it;
    it.elevation = elev;
    it.start_of_frame = sof;
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    shade_pixel(it);
    last_elev = elev;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_shade.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic set_config(logic [12:0] w, logic [23:0] iew, logic [23:0] ins,
                            logic [15:0] se, logic [15:0] ce, logic [15:0] sa,
                            logic [15:0] ca, logic [15:0] thr);
    logic [CfgDataW-1:0] vals [8];
    vals = '{24'(w), iew, ins, 24'(se), 24'(ce), 24'(sa), 24'(ca), 24'(thr)};
    for (int i = 0; i < 8; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= hsdsm_cfg_idx_e'(i);
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    m_width = w; m_inv_ew = iew; m_inv_ns = ins;
    m_sin_e = se; m_cos_e = ce; m_sin_az = sa; m_cos_az = ca; m_thr = thr;
  endtask

  function automatic logic [15:0] rand_trig();
    case ($urandom_range(3))
      0: return 16'sd32767;
      1: return -16'sd32767;
      default: return 16'($signed($urandom_range(65534)) - 32767);
    endcase
  endfunction

  function automatic logic [23:0] rand_inv();
    case ($urandom_range(3))
      0: return 24'd16777215;
      1: return 24'd1;
      default: return 24'($urandom_range(1, 16777215));
    endcase
  endfunction

  // Mostly smooth terrain, sometimes a wild sample
  function automatic logic signed [15:0] next_elev();
    int v;
    if ($urandom_range(9) == 0) return 16'($urandom);
    v = int'(last_elev) + $signed($urandom_range(400)) - 200;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  task automatic test_flat_terrain();
    set_config(13'd3, 24'd559241, 24'd559241, 16'sd23170, 16'sd23170, 16'sd0,
               16'sd32767, 16'sd0);
    for (int i = 0; i < 9; i++) send_sample(16'sh7fff, i == 0);
    for (int i = 0; i < 9; i++) send_sample(16'sh8000, i == 0);
    drain();
  endtask

  task automatic test_extremes();
    set_config(13'd0, 24'd16777215, 24'd1, -16'sd32767, 16'sd32767, 16'sd32767,
               -16'sd32767, -16'sd16384);
    for (int i = 0; i < 9; i++)
      send_sample(i % 2 ? 16'sh8000 : 16'sh7fff, i == 0);
    drain();
    set_config(13'd0, 24'd1, 24'd16777215, 16'sd32767, -16'sd32767, -16'sd32767,
               16'sd32767, 16'sd16384);
    for (int i = 0; i < 9; i++)
      send_sample(i < 3 ? 16'sh8000 : 16'sh7fff, i == 0);
    drain();
  endtask

  // Over-range width, then lower it mid-line so the line ends early
  task automatic test_width_lowered();
    set_config(13'd8191, 24'd16777215, 24'd16777215, 16'sd32767, 16'sd32767,
               16'sd0, 16'sd32767, 16'sd0);
    for (int i = 0; i < 6; i++) send_sample(16'(i * 9000), i == 0);
    drain();
    set_config(13'd3, 24'd16777215, 24'd16777215, 16'sd32767, 16'sd32767,
               16'sd0, 16'sd32767, 16'sd0);
    for (int i = 0; i < 6; i++) send_sample(16'(-i * 7000), 1'b0);
    drain();
  endtask

  task automatic test_backpressure();
    set_config(13'd4, rand_inv(), rand_inv(), rand_trig(), rand_trig(), rand_trig(),
               rand_trig(), 16'sd0);
    send_idle = 0;
    recv_idle = 0;
    -> hold_ev;
    for (int i = 0; i < 24; i++) send_sample(next_elev(), i == 0);
    drain();
  endtask

  task automatic test_random(int n, logic [12:0] w, int s_idle, int r_idle);
    set_config(w, rand_inv(), rand_inv(), rand_trig(), rand_trig(), rand_trig(),
               rand_trig(), 16'($signed($urandom_range(32768)) - 16384));
    send_idle = s_idle;
    recv_idle = r_idle;
    for (int i = 0; i < n; i++)
      send_sample(next_elev(), i == 0 || $urandom_range(199) == 0);
    send_idle = 0;
    recv_idle = 0;
    drain();
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always begin
    @(hold_ev);
    hold_on <= 1'b1;
    repeat (3000) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  always @(posedge clk_i) begin
    hsdsm_out_t exp_r;
    out_stall_i <= hold_on || ($urandom_range(99) < recv_idle);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_shade.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data_o);
      end else begin
        exp_r = pending_shade.pop_front();
        if (out_data_o !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", exp_r, out_data_o);
        end
      end
    end
  end

  initial begin
    col_cnt = 0;
    rows_cnt = 0;
    for (int i = 0; i < 6; i++) win_col[i] = '0;
    for (int i = 0; i < RowDepth; i++) begin
      older_row[i] = '0;
      newer_row[i] = '0;
    end
    m_width = LineWidthRst; m_inv_ew = InvResRst; m_inv_ns = InvResRst;
    m_sin_e = SinElevRst; m_cos_e = CosElevRst; m_sin_az = SinAzRst;
    m_cos_az = CosAzRst; m_thr = ThrRst;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_flat_terrain();
    test_extremes();
    test_width_lowered();
    test_backpressure();
    test_random(300, 13'($urandom_range(3, 12)), 0, 0);
    test_random(300, 13'd40, 49, 0);
    test_random(300, 13'($urandom_range(3, 12)), 0, 49);
    test_random(300, 13'($urandom_range(0, 12)), 23, 23);
    if (mismatches == 0 && pending_shade.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
sv/hsdsm_pkg.sv
sv/hsdsm_ram.sv
sv/hillshade_deep_shadow_mask.sv
sv/hsdsm_checker.sv
tb/tb_top.sv
